>>> rtl/websocket_client_frame_builder_defines.svh
// assertion macros for the websocket client frame builder
// no dependencies; included by the top level only
`ifndef WEBSOCKET_CLIENT_FRAME_BUILDER_DEFINES_SVH
`define WEBSOCKET_CLIENT_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WSFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfb assertion failed");

`endif

>>> rtl/wsfb_pkg.sv
// shared types, constants and helpers for the websocket client frame builder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsfb_pkg;

    typedef enum logic [1:0] {
        ACT_TEXT    = 2'd0,
        ACT_PONG    = 2'd1,
        ACT_CLOSE   = 2'd2,
        ACT_PAYLOAD = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_PONG_MASK  = 2'd0,
        CFG_TEXT_MASK  = 2'd1,
        CFG_CLOSE_MASK = 2'd2
    } cfg_reg_t;

    localparam int unsigned BURST_MAX = 8;
    localparam int unsigned COUNT_W   = $clog2(BURST_MAX + 1);

    localparam logic [7:0]  HDR_TEXT      = 8'h81;
    localparam logic [7:0]  HDR_PONG      = 8'h8A;
    localparam logic [7:0]  HDR_CLOSE     = 8'h88;
    localparam logic [7:0]  MASK_BIT      = 8'h80;
    localparam logic [6:0]  LEN_EXT16     = 7'd126;
    localparam logic [15:0] LEN_SHORT_MAX = 16'd125;
    localparam logic [15:0] CLOSE_CODE    = 16'd1000;
    localparam logic [6:0]  CLOSE_LEN     = 7'd2;

    localparam logic [31:0] PONG_MASK_RST  = 32'h1234_5678;
    localparam logic [31:0] TEXT_MASK_RST  = 32'h0102_0304;
    localparam logic [31:0] CLOSE_MASK_RST = 32'h0506_0708;

    // bytes produced by one input beat, oldest in slot 0
    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        logic [BURST_MAX-1:0]           last;
        logic [BURST_MAX-1:0][7:0]      data;
    } burst_t;

    // mask byte idx, most significant byte first
    function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            2'd3:    b = key[7:0];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wsfb_frame_gen.sv
// frame state and per-beat burst formation
// depends on wsfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfb_frame_gen
    import wsfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] frame_length,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [31:0] pong_mask,
    input  wire logic [31:0] text_mask,
    input  wire logic [31:0] close_mask,
    output burst_t           burst,
    output logic             frame_open
);

    logic        frame_open_reg, frame_open_next;
    logic [31:0] active_mask_reg, active_mask_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] bytes_to_emit_reg, bytes_to_emit_next;
    logic [1:0]  mask_phase_reg, mask_phase_next;

    always_comb
    begin
        logic [31:0] key;
        logic [15:0] emit;
        logic        long_hdr;

        burst              = '0;
        frame_open_next    = frame_open_reg;
        active_mask_next   = active_mask_reg;
        bytes_left_next    = bytes_left_reg;
        bytes_to_emit_next = bytes_to_emit_reg;
        mask_phase_next    = mask_phase_reg;
        key                = text_mask;
        emit               = frame_length;
        long_hdr           = 1'b0;

        case (action_t'(action))
            ACT_PAYLOAD:
            begin
                if (frame_open_reg && (bytes_left_reg != 16'd0))
                begin
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_to_emit_reg != 16'd0)
                    begin
                        bytes_to_emit_next = bytes_to_emit_reg - 16'd1;
                        burst.count   = COUNT_W'(1);
                        burst.data[0] = payload_byte ^ mask_byte(active_mask_reg, mask_phase_reg);
                        burst.last[0] = (bytes_to_emit_next == 16'd0);
                        mask_phase_next = mask_phase_reg + 2'd1;
                    end
                    if (bytes_left_next == 16'd0)
                    begin
                        frame_open_next = 1'b0;
                    end
                end
            end
            ACT_CLOSE:
            begin
                frame_open_next    = 1'b0;
                bytes_left_next    = '0;
                bytes_to_emit_next = '0;
                mask_phase_next    = '0;
                burst.count   = COUNT_W'(8);
                burst.data[0] = HDR_CLOSE;
                burst.data[1] = MASK_BIT | {1'b0, CLOSE_LEN};
                for (int i = 0; i < 4; i++)
                begin
                    burst.data[2+i] = mask_byte(close_mask, 2'(i));
                end
                burst.data[6] = CLOSE_CODE[15:8] ^ mask_byte(close_mask, 2'd0);
                burst.data[7] = CLOSE_CODE[7:0] ^ mask_byte(close_mask, 2'd1);
                burst.last[7] = 1'b1;
            end
            default:
            begin
                // text or pong start
                if (action_t'(action) == ACT_TEXT)
                begin
                    key           = text_mask;
                    emit          = frame_length;
                    long_hdr      = (frame_length > LEN_SHORT_MAX);
                    burst.data[0] = HDR_TEXT;
                end
                else
                begin
                    key           = pong_mask;
                    emit          = (frame_length > LEN_SHORT_MAX) ? LEN_SHORT_MAX
                                                                   : frame_length;
                    burst.data[0] = HDR_PONG;
                end
                if (long_hdr)
                begin
                    burst.count   = COUNT_W'(8);
                    burst.data[1] = MASK_BIT | {1'b0, LEN_EXT16};
                    burst.data[2] = frame_length[15:8];
                    burst.data[3] = frame_length[7:0];
                    for (int i = 0; i < 4; i++)
                    begin
                        burst.data[4+i] = mask_byte(key, 2'(i));
                    end
                end
                else
                begin
                    burst.count   = COUNT_W'(6);
                    burst.data[1] = MASK_BIT | {1'b0, emit[6:0]};
                    for (int i = 0; i < 4; i++)
                    begin
                        burst.data[2+i] = mask_byte(key, 2'(i));
                    end
                    // zero-length frame ends on its last mask byte
                    burst.last[5] = (frame_length == 16'd0);
                end
                active_mask_next   = key;
                bytes_left_next    = frame_length;
                bytes_to_emit_next = emit;
                mask_phase_next    = '0;
                frame_open_next    = (frame_length != 16'd0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg    <= 1'b0;
            active_mask_reg   <= '0;
            bytes_left_reg    <= '0;
            bytes_to_emit_reg <= '0;
            mask_phase_reg    <= '0;
        end
        else if (take)
        begin
            frame_open_reg    <= frame_open_next;
            active_mask_reg   <= active_mask_next;
            bytes_left_reg    <= bytes_left_next;
            bytes_to_emit_reg <= bytes_to_emit_next;
            mask_phase_reg    <= mask_phase_next;
        end
    end

    assign frame_open = frame_open_reg;

endmodule

`default_nettype wire

>>> rtl/wsfb_burst_buf.sv
// output shift register that plays a burst out one byte per beat
// depends on wsfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfb_burst_buf
    import wsfb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire burst_t burst,
    input  wire logic   out_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        room
);

    logic [COUNT_W-1:0]        rem_reg, rem_next;
    logic [BURST_MAX-1:0][7:0] data_reg, data_next;
    logic [BURST_MAX-1:0]      last_reg, last_next;

    always_comb
    begin
        rem_next  = rem_reg;
        data_next = data_reg;
        last_next = last_reg;
        if (load)
        begin
            rem_next  = burst.count;
            data_next = burst.data;
            last_next = burst.last;
        end
        else if (out_valid && out_ready)
        begin
            rem_next = rem_reg - COUNT_W'(1);
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                data_next[i] = data_reg[i+1];
                last_next[i] = last_reg[i+1];
            end
            data_next[BURST_MAX-1] = '0;
            last_next[BURST_MAX-1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = (rem_reg != '0);
    assign out_byte  = data_reg[0];
    assign frame_end = last_reg[0];
    // empty, or the last byte leaves this cycle
    assign room      = (rem_reg == '0) || ((rem_reg == COUNT_W'(1)) && out_ready);

endmodule

`default_nettype wire

>>> rtl/websocket_client_frame_builder.sv
// websocket client frame builder, top level: mask registers and glue
// depends on wsfb_pkg, wsfb_frame_gen, wsfb_burst_buf and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_client_frame_builder_defines.svh"

// usage
//   input channel (in_valid/in_ready): one beat is a start-text, start-pong,
//   close or payload item. output channel (out_valid/out_ready): one beat is
//   one byte of the wire stream, frame_end high on the last byte of a frame.
//   cfg channel (cfg_valid/cfg_ready): writes a mask key, always ready.
// output: the first byte of an item's burst is on out_byte in the cycle after
//   the input beat. headers take 6 or 8 output beats, a close frame 8,
//   a payload byte 1, a dropped byte 0.
// throughput: one input beat per cycle while each produces at most one byte
//   and out_ready is high; a header burst holds in_ready low until its last
//   byte leaves, so the single output port sets the pace of input items.
// stalls: when out_ready is low the burst register holds and in_ready stays
//   low for as long as any byte of the burst is waiting.
// reset: frame closed, burst empty, mask keys back to their defaults.

module websocket_client_frame_builder
    import wsfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] frame_length,
    input  wire logic [7:0]  payload_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             frame_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] pong_mask_reg;
    logic [31:0] text_mask_reg;
    logic [31:0] close_mask_reg;

    logic   in_fire;
    logic   room;
    logic   frame_open;
    burst_t burst;

    assign cfg_ready = 1'b1;

    // mask key registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pong_mask_reg  <= PONG_MASK_RST;
            text_mask_reg  <= TEXT_MASK_RST;
            close_mask_reg <= CLOSE_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PONG_MASK:  pong_mask_reg  <= cfg_data;
                CFG_TEXT_MASK:  text_mask_reg  <= cfg_data;
                CFG_CLOSE_MASK: close_mask_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // accept whenever the burst register is free by the next edge
    assign in_ready = room;
    assign in_fire  = in_valid && in_ready;

    wsfb_frame_gen u_frame_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (in_fire),
        .action       (action),
        .frame_length (frame_length),
        .payload_byte (payload_byte),
        .pong_mask    (pong_mask_reg),
        .text_mask    (text_mask_reg),
        .close_mask   (close_mask_reg),
        .burst        (burst),
        .frame_open   (frame_open)
    );

    wsfb_burst_buf u_burst_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .burst     (burst),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .room      (room)
    );

    // a close beat always leads with its header byte next cycle
    `WSFB_ASSERT_NEXT(a_close_hdr, clk, rst_n,
        in_fire && (action == ACT_CLOSE), out_valid && (out_byte == HDR_CLOSE))

    // a payload beat with no open frame produces nothing
    `WSFB_ASSERT_NEXT(a_orphan_payload, clk, rst_n,
        in_fire && (action == ACT_PAYLOAD) && !frame_open, !out_valid)

    // a frame end is always the last byte of its burst
    `WSFB_ASSERT_NOW(a_end_last, clk, rst_n,
        out_valid && frame_end, out_ready == in_ready)

endmodule

`default_nettype wire
